/* hdl/ldcm_pkg.sv */
// ----------------------------------------------------------------------------
// ldcm_pkg
// Shared types and constants of the literal and digit-class pattern matcher.
// ----------------------------------------------------------------------------
package ldcm_pkg;

    localparam int unsigned TEXT_W     = 8;
    localparam int unsigned POS_OUT_W  = 12;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned MASK_W     = 16;
    localparam int unsigned CHARS_W    = 64;

    localparam logic [TEXT_W-1:0] DIGIT_LO = 8'h30;
    localparam logic [TEXT_W-1:0] DIGIT_HI = 8'h39;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

    typedef enum logic [1:0] {
        REG_CHARS_LO   = 2'd0,
        REG_CHARS_HI   = 2'd1,
        REG_DIGIT_MASK = 2'd2,
        REG_LENGTH     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CHARS_W-1:0] chars_hi;
        logic [CHARS_W-1:0] chars_lo;
        logic [MASK_W-1:0]  digit_mask;
        logic [LEN_W-1:0]   pattern_length;
    } t_cfg;

    typedef struct packed {
        logic                 hit;
        logic [POS_OUT_W-1:0] start_position;
        logic                 at_line_end;
    } t_match;

endpackage

/* hdl/ldcm_if.sv */
// ----------------------------------------------------------------------------
// ldcm_if
// Valid/ready channels for text bytes in and match reports out.
// ----------------------------------------------------------------------------
interface ldcm_in_if;
    logic                        valid;
    logic                        ready;
    logic [ldcm_pkg::TEXT_W-1:0] text_char;
    logic                        line_end;

    modport source (output valid, output text_char, output line_end, input ready);
    modport sink (input valid, input text_char, input line_end, output ready);
endinterface

interface ldcm_out_if;
    logic                           valid;
    logic                           ready;
    logic [ldcm_pkg::POS_OUT_W-1:0] start_position;
    logic                           at_line_end;

    modport source (output valid, output start_position, output at_line_end, input ready);
    modport sink (input valid, input start_position, input at_line_end, output ready);
endinterface

/* hdl/ldcm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ldcm_cfg_regs
// APB register file holding the pattern bytes, digit-class mask and length.
// ----------------------------------------------------------------------------
module ldcm_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ldcm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ldcm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [ldcm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output ldcm_pkg::t_cfg                    o_cfg
);

    logic [ldcm_pkg::CHARS_W-1:0] r_chars_lo;
    logic [ldcm_pkg::CHARS_W-1:0] r_chars_hi;
    logic [ldcm_pkg::MASK_W-1:0]  r_digit_mask;
    logic [ldcm_pkg::LEN_W-1:0]   r_length;
    logic                         w_wr;
    ldcm_pkg::t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = ldcm_pkg::t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars_lo   <= '0;
            r_chars_hi   <= '0;
            r_digit_mask <= '0;
            r_length     <= ldcm_pkg::LEN_RESET;
        end else if (w_wr) begin
            case (w_idx)
                ldcm_pkg::REG_CHARS_LO:   r_chars_lo   <= pwdata;
                ldcm_pkg::REG_CHARS_HI:   r_chars_hi   <= pwdata;
                ldcm_pkg::REG_DIGIT_MASK: r_digit_mask <= pwdata[ldcm_pkg::MASK_W-1:0];
                ldcm_pkg::REG_LENGTH:     r_length     <= pwdata[ldcm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ldcm_pkg::REG_CHARS_LO:   prdata = r_chars_lo;
            ldcm_pkg::REG_CHARS_HI:   prdata = r_chars_hi;
            ldcm_pkg::REG_DIGIT_MASK: prdata = ldcm_pkg::CFG_DATA_W'(r_digit_mask);
            ldcm_pkg::REG_LENGTH:     prdata = ldcm_pkg::CFG_DATA_W'(r_length);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg.chars_lo       = r_chars_lo;
    assign o_cfg.chars_hi       = r_chars_hi;
    assign o_cfg.digit_mask     = r_digit_mask;
    assign o_cfg.pattern_length = r_length;

endmodule

/* hdl/ldcm_match_core.sv */
// ----------------------------------------------------------------------------
// ldcm_match_core
// Shift-and update of the active prefixes and line position for one byte.
// ----------------------------------------------------------------------------
module ldcm_match_core #(
    parameter int unsigned MAX_ELEMENTS = 16,
    parameter int unsigned LINE_MAX     = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [ldcm_pkg::TEXT_W-1:0]   i_char,
    input  logic                          i_last,
    input  ldcm_pkg::t_cfg                i_cfg,
    output ldcm_pkg::t_match              o_match
);

    localparam int unsigned POS_W = $clog2(LINE_MAX);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

    logic [MAX_ELEMENTS-1:0]       r_active;
    logic [POS_W-1:0]              r_pos;
    logic                          r_ovf;
    logic [MAX_ELEMENTS-1:0]       n_active;
    logic [POS_W-1:0]              n_pos;
    logic                          n_ovf;
    logic [ldcm_pkg::LEN_W-1:0]    w_n;
    logic [MAX_ELEMENTS-1:0]       w_len_mask;
    logic [MAX_ELEMENTS-1:0]       w_top_mask;
    logic [MAX_ELEMENTS-1:0]       w_accept;
    logic [MAX_ELEMENTS-1:0]       w_step;
    logic [2*ldcm_pkg::CHARS_W-1:0] w_chars;
    logic                          w_digit;
    logic [POS_W+ldcm_pkg::POS_OUT_W-1:0] w_pos_ext;
    logic [ldcm_pkg::POS_OUT_W-1:0] w_pos12;

    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            w_n = ldcm_pkg::LEN_W'(1);
        end else if (i_cfg.pattern_length > ldcm_pkg::LEN_W'(MAX_ELEMENTS)) begin
            w_n = ldcm_pkg::LEN_W'(MAX_ELEMENTS);
        end else begin
            w_n = i_cfg.pattern_length;
        end
    end

    assign w_chars = {i_cfg.chars_hi, i_cfg.chars_lo};
    assign w_digit = i_char inside {[ldcm_pkg::DIGIT_LO:ldcm_pkg::DIGIT_HI]};

    always_comb begin
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
            w_len_mask[k] = ldcm_pkg::LEN_W'(k) < w_n;
            w_top_mask[k] = ldcm_pkg::LEN_W'(k + 1) == w_n;
            if (i_cfg.digit_mask[k]) begin
                w_accept[k] = w_digit;
            end else begin
                w_accept[k] = w_chars[8*k +: 8] == i_char;
            end
        end
    end

    assign w_step    = ((r_active << 1) | MAX_ELEMENTS'(1)) & w_accept & w_len_mask;
    assign w_pos_ext = {{ldcm_pkg::POS_OUT_W{1'b0}}, r_pos};
    assign w_pos12   = w_pos_ext[ldcm_pkg::POS_OUT_W-1:0];

    assign o_match.hit            = !r_ovf && (|(w_step & w_top_mask));
    assign o_match.start_position = w_pos12 - ldcm_pkg::POS_OUT_W'(w_n)
                                    + ldcm_pkg::POS_OUT_W'(1);
    assign o_match.at_line_end    = i_last;

    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        n_ovf    = r_ovf;
        if (i_last) begin
            n_active = '0;
            n_pos    = '0;
            n_ovf    = 1'b0;
        end else if (!r_ovf) begin
            if (r_pos == POS_LAST) begin
                n_active = '0;
                n_ovf    = 1'b1;
            end else begin
                n_active = w_step;
                n_pos    = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_pos    <= '0;
            r_ovf    <= 1'b0;
        end else if (i_adv) begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_ovf    <= n_ovf;
        end
    end

    a_ovf_clears_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_active == '0 && r_pos == POS_LAST))
        else $error("active prefixes held past line overflow");

    a_last_clears_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_last) |=> (r_pos == '0 && !r_ovf && r_active == '0))
        else $error("line state not cleared after last byte");

    a_no_hit_in_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> !o_match.hit)
        else $error("match reported after line overflow");

endmodule

/* hdl/literal_digit_class_matcher.sv */
// ----------------------------------------------------------------------------
// literal_digit_class_matcher
// Shift-and matcher of a literal and digit-class pattern over text lines.
// A byte taken is held in the input register, then its match is registered
// in the match register. A match held on the output stalls the input.
// Throughput: one text byte per cycle while no held match stalls the input,
// set by the single shift-and update between the input and match registers.
// Reset: synchronous, active low; clears line state and loads length 1.
// ----------------------------------------------------------------------------
module literal_digit_class_matcher #(
    parameter int unsigned MAX_ELEMENTS = 16,
    parameter int unsigned LINE_MAX     = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ldcm_in_if.sink                           i_text,
    ldcm_out_if.source                        o_match,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ldcm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ldcm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [ldcm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    ldcm_pkg::t_cfg                 w_cfg;
    ldcm_pkg::t_match               w_match;
    logic                           r_in_valid;
    logic [ldcm_pkg::TEXT_W-1:0]    r_in_char;
    logic                           r_in_last;
    logic                           r_out_valid;
    logic [ldcm_pkg::POS_OUT_W-1:0] r_out_start;
    logic                           r_out_end;
    logic                           w_out_free;
    logic                           w_adv;
    logic                           w_take;

    ldcm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ldcm_match_core #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LINE_MAX     (LINE_MAX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .i_cfg   (w_cfg),
        .o_match (w_match)
    );

    assign w_out_free   = !r_out_valid || o_match.ready;
    assign w_adv        = r_in_valid && w_out_free;
    assign i_text.ready = !r_in_valid || w_adv;
    assign w_take       = i_text.valid && i_text.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_char <= i_text.text_char;
            r_in_last <= i_text.line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_adv && w_match.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_match.hit) begin
            r_out_start <= w_match.start_position;
            r_out_end   <= w_match.at_line_end;
        end
    end

    assign o_match.valid          = r_out_valid;
    assign o_match.start_position = r_out_start;
    assign o_match.at_line_end    = r_out_end;

    a_hit_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_match.hit) |=> r_out_valid)
        else $error("match lost on its way to the output register");

    a_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_last)))
        else $error("held text byte dropped or overwritten");

    a_no_adv_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_match.ready) |-> !w_adv)
        else $error("byte processed while a match is still pending");

endmodule

/* tb/sv/tb_literal_digit_class_matcher.sv */
// ----------------------------------------------------------------------------
// tb_literal_digit_class_matcher
// Streams text lines into the matcher and checks every match report against
// a shift-and predictor of its own. A short directed part covers the default
// pattern, the digit class at its edges, out-of-range pattern lengths and a
// full-length pattern. It is followed by random phases with random patterns,
// lines seeded with whole and cut pattern instances, patterns changed in the
// middle of a line, one line that runs past the position limit, and random
// idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_literal_digit_class_matcher;

    timeunit 1ns;
    timeprecision 1ps;

    import ldcm_pkg::*;

    localparam int unsigned MAX_ELEMENTS     = 16;
    localparam int unsigned LINE_MAX         = 4096;
    localparam int unsigned RANDOM_ITEMS     = 2000;
    localparam int unsigned QUIET_FROM       = 1600;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned LONG_LINE_LEN    = LINE_MAX + 8;

    typedef struct packed {
        logic [TEXT_W-1:0] text_char;
        logic              line_end;
    } t_text_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    ldcm_in_if  text_if ();
    ldcm_out_if match_if ();

    literal_digit_class_matcher #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LINE_MAX     (LINE_MAX)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_match (match_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_text_req         text_backlog[$];
    t_match            expected_hits[$];
    logic [TEXT_W-1:0] line_buf[$];

    t_cfg              cfg_model;
    logic [15:0]       active_prefixes;
    int unsigned       line_pos;
    bit                line_overflow;

    bit                text_taken;
    bit                quiet;
    bit                hold_arm;
    bit                long_hold;
    int                send_gap;
    int                recv_gap;
    int                err_count;
    int                random_items;

    always #5 i_clk = ~i_clk;

    function automatic int unsigned elem_count();
        if (cfg_model.pattern_length == 0) begin
            return 1;
        end
        if (cfg_model.pattern_length > MAX_ELEMENTS) begin
            return MAX_ELEMENTS;
        end
        return cfg_model.pattern_length;
    endfunction

    function automatic logic [TEXT_W-1:0] elem_char(int unsigned k);
        if (k < 8) begin
            return cfg_model.chars_lo[8*k +: 8];
        end
        return cfg_model.chars_hi[8*(k-8) +: 8];
    endfunction

    function automatic t_match shift_and_step(logic [TEXT_W-1:0] c, logic last);
        int unsigned n;
        logic [15:0] accept;
        logic [16:0] len_mask;
        bit          digit_byte;
        t_match      r;
        n = elem_count();
        digit_byte = (c >= DIGIT_LO) && (c <= DIGIT_HI);
        for (int k = 0; k < 16; k++) begin
            accept[k] = cfg_model.digit_mask[k] ? digit_byte : (elem_char(k) == c);
        end
        len_mask = (17'd1 << n) - 17'd1;
        r = '0;
        if (!line_overflow) begin
            active_prefixes = ((active_prefixes << 1) | 16'd1) & accept & len_mask[15:0];
            if (active_prefixes[n-1]) begin
                r.hit            = 1'b1;
                r.start_position = POS_OUT_W'(line_pos - (n - 1));
                r.at_line_end    = last;
            end
        end
        if (last) begin
            active_prefixes = '0;
            line_pos        = 0;
            line_overflow   = 1'b0;
        end else if (!line_overflow) begin
            if (line_pos + 1 >= LINE_MAX) begin
                line_overflow   = 1'b1;
                active_prefixes = '0;
            end else begin
                line_pos++;
            end
        end
        return r;
    endfunction

    // Sender: a new request is offered once the previous one has been taken.
    always @(negedge i_clk) begin
        t_text_req req;
        if (!text_if.valid || text_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                text_if.valid <= 1'b0;
            end else if (text_backlog.size() > 0) begin
                req = text_backlog.pop_front();
                text_if.valid     <= 1'b1;
                text_if.text_char <= req.text_char;
                text_if.line_end  <= req.line_end;
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 14);
                end
            end else begin
                text_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (long_hold) begin
            match_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            match_if.ready <= 1'b0;
        end else begin
            match_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 14);
            end
        end
    end

    initial begin
        long_hold = 1'b0;
        wait (hold_arm);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        long_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        t_match want;
        text_taken = i_rst_n && text_if.valid && text_if.ready;
        if (i_rst_n && match_if.valid && match_if.ready) begin
            if (expected_hits.size() == 0) begin
                $error("unexpected match: start_position %0d, at_line_end %0d",
                       match_if.start_position, match_if.at_line_end);
                err_count++;
            end else begin
                want = expected_hits.pop_front();
                if (match_if.start_position !== want.start_position) begin
                    $error("start_position: expected %0d, got %0d",
                           want.start_position, match_if.start_position);
                    err_count++;
                end
                if (match_if.at_line_end !== want.at_line_end) begin
                    $error("at_line_end: expected %0d, got %0d",
                           want.at_line_end, match_if.at_line_end);
                    err_count++;
                end
            end
        end
        if (text_taken) begin
            want = shift_and_step(text_if.text_char, text_if.line_end);
            if (want.hit) begin
                expected_hits.insert(expected_hits.size(), want);
            end
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_CHARS_LO:   cfg_model.chars_lo       = value;
            REG_CHARS_HI:   cfg_model.chars_hi       = value;
            REG_DIGIT_MASK: cfg_model.digit_mask     = value[MASK_W-1:0];
            REG_LENGTH:     cfg_model.pattern_length = value[LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic push_text(logic [TEXT_W-1:0] c, logic last);
        t_text_req req;
        req.text_char = c;
        req.line_end  = last;
        text_backlog.insert(text_backlog.size(), req);
    endtask

    task automatic wait_idle();
        while (text_backlog.size() != 0 || text_if.valid || expected_hits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [TEXT_W-1:0] elem_sample(int unsigned k);
        if (cfg_model.digit_mask[k]) begin
            return DIGIT_LO + TEXT_W'($urandom_range(0, 9));
        end
        return elem_char(k);
    endfunction

    function automatic logic [TEXT_W-1:0] pick_pattern_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 8'h61 + TEXT_W'($urandom_range(0, 2));
        end else if (r < 75) begin
            return DIGIT_LO + TEXT_W'($urandom_range(0, 9));
        end else if (r < 90) begin
            return TEXT_W'($urandom_range(0, 255));
        end
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endfunction

    // Fills line_buf with text that holds whole and cut pattern instances.
    task automatic build_text(int len);
        int unsigned n;
        int unsigned cut;
        int r;
        n = elem_count();
        line_buf.delete();
        while (line_buf.size() < len) begin
            if ($urandom_range(0, 99) < 12) begin
                cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
                for (int unsigned k = 0; k < cut; k++) begin
                    line_buf.insert(line_buf.size(), elem_sample(k));
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    line_buf.insert(line_buf.size(), elem_sample($urandom_range(0, n - 1)));
                end else if (r < 50) begin
                    line_buf.insert(line_buf.size(), DIGIT_LO + TEXT_W'($urandom_range(0, 9)));
                end else if (r < 65) begin
                    line_buf.insert(line_buf.size(), 8'h61 + TEXT_W'($urandom_range(0, 2)));
                end else begin
                    line_buf.insert(line_buf.size(), TEXT_W'($urandom_range(0, 255)));
                end
            end
        end
        while (line_buf.size() > len) void'(line_buf.pop_back());
    endtask

    task automatic emit_line(bit close);
        foreach (line_buf[i]) begin
            push_text(line_buf[i], close && (i == line_buf.size() - 1));
        end
    endtask

    task automatic rand_config(bit write_all);
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] mask_word;
        logic [CFG_DATA_W-1:0] len_word;
        int r;
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = pick_pattern_char();
            hi[8*k +: 8] = pick_pattern_char();
        end
        mask_word = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 45) begin
            mask_word[MASK_W-1:0] = '0;
        end else if (r < 55) begin
            mask_word[MASK_W-1:0] = '1;
        end
        len_word = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 8) begin
            len_word[LEN_W-1:0] = '0;
        end else if (r < 16) begin
            len_word[LEN_W-1:0] = LEN_W'(MAX_ELEMENTS);
        end else if (r < 24) begin
            len_word[LEN_W-1:0] = LEN_W'($urandom_range(MAX_ELEMENTS + 1, 31));
        end else if (r < 34) begin
            len_word[LEN_W-1:0] = LEN_W'(1);
        end else begin
            len_word[LEN_W-1:0] = LEN_W'($urandom_range(2, 6));
        end
        if (write_all || $urandom_range(0, 3) != 0) reg_write(REG_CHARS_LO, lo);
        if (write_all || $urandom_range(0, 3) != 0) reg_write(REG_CHARS_HI, hi);
        if (write_all || $urandom_range(0, 3) != 0) reg_write(REG_DIGIT_MASK, mask_word);
        if (write_all || $urandom_range(0, 3) != 0) reg_write(REG_LENGTH, len_word);
    endtask

    initial begin
        int phase;
        int target;
        int count;
        int len;
        int r;
        bit close;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        text_if.valid      = 1'b0;
        text_if.text_char  = '0;
        text_if.line_end   = 1'b0;
        match_if.ready     = 1'b0;
        cfg_model          = '0;
        cfg_model.pattern_length = LEN_RESET;
        active_prefixes    = '0;
        line_pos           = 0;
        line_overflow      = 1'b0;
        quiet              = 1'b0;
        hold_arm           = 1'b0;
        send_gap           = 0;
        recv_gap           = 0;
        err_count          = 0;
        random_items       = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // The reset pattern is one element holding a zero byte.
        push_text(8'h00, 1'b0);
        push_text(8'h00, 1'b1);
        wait_idle();

        // Literal, digit class, literal, with both edge digits and the byte just above the digits.
        reg_write(REG_CHARS_LO, 64'h0000_0000_0063_7861);
        reg_write(REG_DIGIT_MASK, 64'h0000_0000_0000_0002);
        reg_write(REG_LENGTH, 64'd3);
        push_text(8'h61, 1'b0);
        push_text(8'h30, 1'b0);
        push_text(8'h63, 1'b0);
        push_text(8'h61, 1'b0);
        push_text(8'h3A, 1'b0);
        push_text(8'h63, 1'b0);
        push_text(8'h61, 1'b0);
        push_text(8'h39, 1'b0);
        push_text(8'h63, 1'b1);
        wait_idle();

        // A zero length acts as one element.
        reg_write(REG_CHARS_LO, '1);
        reg_write(REG_DIGIT_MASK, 64'd0);
        reg_write(REG_LENGTH, 64'd0);
        push_text(8'hFF, 1'b0);
        push_text(8'hFF, 1'b1);
        wait_idle();

        // An oversized length acts as the full sixteen digit-class elements.
        reg_write(REG_CHARS_HI, '1);
        reg_write(REG_DIGIT_MASK, 64'h0000_0000_0000_FFFF);
        reg_write(REG_LENGTH, 64'd31);
        for (int i = 0; i < 16; i++) begin
            push_text(DIGIT_LO + TEXT_W'(i % 10), i == 15);
        end
        wait_idle();

        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= QUIET_FROM) begin
                quiet = 1'b1;
            end
            rand_config(phase == 0);
            if (phase == 1) begin
                reg_write(REG_DIGIT_MASK, 64'h0000_0000_0000_0001);
                reg_write(REG_LENGTH, 64'd1);
                hold_arm = 1'b1;
            end
            if (phase == 3) begin
                reg_write(REG_CHARS_LO, 64'h0000_0000_0062_3561);
                reg_write(REG_DIGIT_MASK, 64'h0000_0000_0000_0002);
                reg_write(REG_LENGTH, 64'd3);
                build_text(LONG_LINE_LEN);
                line_buf[LINE_MAX-3] = 8'h61;
                line_buf[LINE_MAX-2] = 8'h37;
                line_buf[LINE_MAX-1] = 8'h62;
                line_buf[LINE_MAX+1] = 8'h61;
                line_buf[LINE_MAX+2] = 8'h31;
                line_buf[LINE_MAX+3] = 8'h62;
                emit_line(1'b1);
            end
            target = $urandom_range(100, 250);
            count  = 0;
            while (count < target) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    len = 1;
                end else if (r < 85) begin
                    len = $urandom_range(1, 40);
                end else begin
                    len = $urandom_range(41, 200);
                end
                close = !((count + len >= target) && $urandom_range(0, 1));
                build_text(len);
                emit_line(close);
                count += len;
            end
            random_items += count;
            wait_idle();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0 && expected_hits.size() == 0) begin
            $display("tb_literal_digit_class_matcher: done, clean");
        end else begin
            $display("tb_literal_digit_class_matcher: done, errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_literal_digit_class_matcher: done, errors");
        $finish;
    end

endmodule

/* literal_digit_class_matcher.f */
hdl/ldcm_pkg.sv
hdl/ldcm_if.sv
hdl/ldcm_cfg_regs.sv
hdl/ldcm_match_core.sv
hdl/literal_digit_class_matcher.sv
tb/sv/tb_literal_digit_class_matcher.sv
